/* rtl/infix_expression_evaluator_unit_assert.svh */
// Assertion macros used by the evaluator back end (iee_back)
`ifndef INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define IEE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define IEE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/iee_pkg.sv */
package iee_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [8:0] BAL_MAX = 9'd511;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5,
    OP_POW  = 3'd6,
    OP_NEG  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNBAL   = 3'd1,
    ST_OPERAND = 3'd2,
    ST_ZERO    = 3'd3,
    ST_NEGEXP  = 3'd4,
    ST_OVER    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    TK_NONE,
    TK_OPEN,
    TK_CLOSE,
    TK_BINOP,
    TK_NEG,
    TK_END
  } tok_kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NUM,
    B_LOOP,
    B_POP,
    B_APPLY,
    B_WAIT,
    B_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    AR_IDLE,
    AR_MUL,
    AR_POW,
    AR_DIV,
    AR_SIGN,
    AR_DONE
  } arith_state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] character;
  } item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } result_t;

  typedef struct packed {
    logic        has_num;
    logic [63:0] num;
    tok_kind_e   kind;
    op_e         op;
    logic        unbal;
  } tok_t;

  typedef struct packed {
    logic        start;
    op_e         op;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  function automatic logic [2:0] prec_of(op_e op);
    case (op)
      OP_OPEN:               prec_of = 3'd0;
      OP_ADD, OP_SUB:        prec_of = 3'd1;
      OP_MUL, OP_DIV, OP_MOD: prec_of = 3'd2;
      OP_POW:                prec_of = 3'd3;
      OP_NEG:                prec_of = 3'd4;
      default:               prec_of = 3'd0;
    endcase
  endfunction

  function automatic logic is_op_char(logic [7:0] c);
    is_op_char = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
                 (c == CH_SLASH) || (c == CH_PCT) || (c == CH_CARET);
  endfunction

endpackage

/* rtl/infix_expression_evaluator_unit.sv */
// An item is accepted in the cycle it is offered unless the 4-entry token queue is full.
// Back end: each token runs through B_NUM and B_LOOP, each operator applied through B_POP and
// B_APPLY; multiply, divide/modulo and power then wait in B_WAIT for iee_arith (one shared
// 32x32 multiplier, radix-2 divider). The result is registered in B_OUT, and the back end takes
// the next token from the queue only once it is back in B_IDLE.
// Reset (rst_ni low, async) empties both stacks and the queue; no memory clearing pass.
module infix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  iee_pkg::item_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output iee_pkg::result_t out_data_o
);
  import iee_pkg::*;

  tok_t f_tok, q_tok;
  logic f_push, q_full, q_valid, q_pop;

  iee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .tok_push_o (f_push),
    .tok_full_i (q_full),
    .tok_o      (f_tok)
  );

  iee_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_tok),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_tok)
  );

  iee_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_tok),
    .tok_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/iee_front.sv */
module iee_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  iee_pkg::item_t in_data_i,
  output logic           tok_push_o,
  input  logic           tok_full_i,
  output iee_pkg::tok_t  tok_o
);
  import iee_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic        in_num_q, in_num_d;
  logic [7:0]  prev_q, prev_d;
  logic        start_q, start_d;
  logic [8:0]  bal_q, bal_d;
  logic        unbal_q, unbal_d;
  logic        accept;
  logic [7:0]  c;
  logic        emit;

  assign in_stall_o = tok_full_i;
  assign accept     = in_valid_i && !tok_full_i;
  assign c          = in_data_i.character;

  always_comb begin
    acc_d         = acc_q;
    in_num_d      = in_num_q;
    prev_d        = prev_q;
    start_d       = start_q;
    bal_d         = bal_q;
    unbal_d       = unbal_q;
    tok_o.has_num = in_num_q;
    tok_o.num     = acc_q;
    tok_o.kind    = TK_NONE;
    tok_o.op      = OP_ADD;
    tok_o.unbal   = 1'b0;
    emit          = 1'b0;
    if (in_data_i.operation) begin
      tok_o.kind  = TK_END;
      tok_o.unbal = unbal_q || (bal_q != 9'd0);
      emit        = 1'b1;
      acc_d       = 64'd0;
      in_num_d    = 1'b0;
      prev_d      = 8'd0;
      start_d     = 1'b1;
      bal_d       = 9'd0;
      unbal_d     = 1'b0;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      acc_d    = (acc_q << 3) + (acc_q << 1) + {60'd0, c[3:0]};
      in_num_d = 1'b1;
      prev_d   = c;
      start_d  = 1'b0;
    end else begin
      acc_d    = 64'd0;
      in_num_d = 1'b0;
      if (c == CH_LPAR) begin
        if (bal_q >= BAL_MAX) unbal_d = 1'b1;
        else bal_d = bal_q + 9'd1;
        tok_o.kind = TK_OPEN;
        tok_o.op   = OP_OPEN;
        prev_d     = c;
        start_d    = 1'b0;
      end else if (c == CH_RPAR) begin
        if (bal_q == 9'd0) begin
          unbal_d = 1'b1;
        end else begin
          bal_d      = bal_q - 9'd1;
          tok_o.kind = TK_CLOSE;
        end
        prev_d  = c;
        start_d = 1'b0;
      end else if (is_op_char(c)) begin
        if (c == CH_MINUS && (start_q || prev_q == CH_LPAR || is_op_char(prev_q))) begin
          tok_o.kind = TK_NEG;
          tok_o.op   = OP_NEG;
        end else begin
          tok_o.kind = TK_BINOP;
          case (c)
            CH_PLUS:  tok_o.op = OP_ADD;
            CH_MINUS: tok_o.op = OP_SUB;
            CH_STAR:  tok_o.op = OP_MUL;
            CH_SLASH: tok_o.op = OP_DIV;
            CH_PCT:   tok_o.op = OP_MOD;
            default:  tok_o.op = OP_POW;
          endcase
        end
        prev_d  = c;
        start_d = 1'b0;
      end
      emit = in_num_q || (tok_o.kind != TK_NONE);
    end
  end

  assign tok_push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= 64'd0;
      in_num_q <= 1'b0;
      prev_q   <= 8'd0;
      start_q  <= 1'b1;
      bal_q    <= 9'd0;
      unbal_q  <= 1'b0;
    end else if (accept) begin
      acc_q    <= acc_d;
      in_num_q <= in_num_d;
      prev_q   <= prev_d;
      start_q  <= start_d;
      bal_q    <= bal_d;
      unbal_q  <= unbal_d;
    end
  end

endmodule

/* rtl/iee_fifo.sv */
module iee_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  iee_pkg::tok_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output iee_pkg::tok_t data_o
);
  import iee_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  tok_t            mem_q [FIFO_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q;
  logic            do_pop;

  assign full_o  = (cnt_q == (PW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (do_pop) rd_q <= rd_q + PW'(1);
      if (push_i && !do_pop) cnt_q <= cnt_q + (PW+1)'(1);
      else if (!push_i && do_pop) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

endmodule

/* rtl/iee_arith.sv */
module iee_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iee_pkg::arith_req_t req_i,
  output logic                done_o,
  output logic [63:0]         res_o
);
  import iee_pkg::*;

  arith_state_e state_q, state_d;
  logic [63:0]  x_q, y_q, pr_q, lo_q;
  logic [31:0]  hi_q;
  logic [1:0]   step_q;
  logic         pow_q, dst_a_q, mod_q, nq_q, nr_q;
  logic [63:0]  r_q, a_q, b_q;
  logic [63:0]  rem_q, quo_q, dv_q;
  logic [5:0]   cnt_q;
  logic [63:0]  res_q;
  logic [31:0]  ma, mb;
  logic [63:0]  product, trial;
  logic         ge;

  always_comb begin
    case (step_q)
      2'd0:    begin ma = x_q[31:0];  mb = y_q[31:0];  end
      2'd1:    begin ma = x_q[31:0];  mb = y_q[63:32]; end
      default: begin ma = x_q[63:32]; mb = y_q[31:0];  end
    endcase
  end

  assign product = lo_q + {hi_q + pr_q[31:0], 32'd0};
  assign trial   = {rem_q[62:0], quo_q[63]};
  assign ge      = (trial >= dv_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      AR_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            OP_MUL:         state_d = AR_MUL;
            OP_DIV, OP_MOD: state_d = AR_DIV;
            default:        state_d = AR_POW;
          endcase
        end
      end
      AR_MUL: begin
        if (step_q == 2'd3) begin
          if (!pow_q) state_d = AR_DONE;
          else if (dst_a_q) state_d = AR_POW;
        end
      end
      AR_POW:  if (b_q != 64'd0) state_d = AR_MUL; else state_d = AR_DONE;
      AR_DIV:  if (cnt_q == 6'd63) state_d = AR_SIGN;
      AR_SIGN: state_d = AR_DONE;
      AR_DONE: state_d = AR_IDLE;
      default: state_d = AR_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == AR_DONE);
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= AR_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      AR_IDLE: begin
        step_q <= 2'd0;
        cnt_q  <= 6'd0;
        x_q    <= req_i.a;
        y_q    <= req_i.b;
        pow_q  <= (req_i.op == OP_POW);
        mod_q  <= (req_i.op == OP_MOD);
        r_q    <= 64'd1;
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        nq_q   <= req_i.a[63] ^ req_i.b[63];
        nr_q   <= req_i.a[63];
        quo_q  <= req_i.a[63] ? (64'd0 - req_i.a) : req_i.a;
        dv_q   <= req_i.b[63] ? (64'd0 - req_i.b) : req_i.b;
        rem_q  <= 64'd0;
      end
      AR_MUL: begin
        pr_q   <= {32'd0, ma} * {32'd0, mb};
        step_q <= step_q + 2'd1;
        if (step_q == 2'd1) lo_q <= pr_q;
        if (step_q == 2'd2) hi_q <= pr_q[31:0];
        if (step_q == 2'd3) begin
          if (!pow_q) begin
            res_q <= product;
          end else if (dst_a_q) begin
            a_q <= product;
            b_q <= b_q >> 1;
          end else begin
            // r updated; square a next
            r_q     <= product;
            x_q     <= a_q;
            y_q     <= a_q;
            dst_a_q <= 1'b1;
          end
        end
      end
      AR_POW: begin
        step_q <= 2'd0;
        res_q  <= r_q;
        if (b_q[0]) begin
          x_q     <= r_q;
          y_q     <= a_q;
          dst_a_q <= 1'b0;
        end else begin
          x_q     <= a_q;
          y_q     <= a_q;
          dst_a_q <= 1'b1;
        end
      end
      AR_DIV: begin
        cnt_q <= cnt_q + 6'd1;
        rem_q <= ge ? (trial - dv_q) : trial;
        quo_q <= {quo_q[62:0], ge};
      end
      AR_SIGN: begin
        if (mod_q) res_q <= nr_q ? (64'd0 - rem_q) : rem_q;
        else res_q <= nq_q ? (64'd0 - quo_q) : quo_q;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/iee_back.sv */
`include "infix_expression_evaluator_unit_assert.svh"

module iee_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  iee_pkg::tok_t    tok_i,
  output logic             tok_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output iee_pkg::result_t out_data_o
);
  import iee_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  back_state_e state_q, state_d;
  tok_t        tok_q;
  logic [2:0]  ot_q;
  logic [2:0]  cur_q;
  logic        skip_q;
  logic [63:0] tv_q;
  logic [CW-1:0] ocnt_q, vcnt_q;
  status_e     err_q;
  logic        unbal_q;
  logic        out_valid_q;
  result_t     out_q;

  logic [2:0]  op_mem [STACK_DEPTH];
  logic [63:0] val_mem [STACK_DEPTH];
  logic [2:0]  op_rd_q;
  logic [63:0] val_rd_q;

  logic [CW-1:0] ocnt_m1, ocnt_m2, vcnt_m1, vcnt_m2;
  logic        err_set, pop_cond, out_free;
  logic        op_we, val_we;
  op_e         top_op, cur_op;
  status_e     fin_err, fin_st;
  arith_req_t  areq;
  logic        a_done;
  logic [63:0] a_res;

  assign ocnt_m1  = ocnt_q - CW'(1);
  assign ocnt_m2  = ocnt_q - CW'(2);
  assign vcnt_m1  = vcnt_q - CW'(1);
  assign vcnt_m2  = vcnt_q - CW'(2);
  assign err_set  = (err_q != ST_OK);
  assign top_op   = op_e'(ot_q);
  assign cur_op   = op_e'(cur_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_cond = (tok_q.op == OP_POW) ? (prec_of(top_op) > prec_of(tok_q.op))
                                         : (prec_of(top_op) >= prec_of(tok_q.op));

  assign fin_err = err_set ? err_q : ((vcnt_q != CW'(1)) ? ST_OPERAND : ST_OK);
  assign fin_st  = (tok_q.unbal || unbal_q) ? ST_UNBAL : fin_err;

  assign tok_pop_o   = (state_q == B_IDLE) && tok_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  iee_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .done_o (a_done),
    .res_o  (a_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (tok_valid_i) state_d = B_NUM;
      B_NUM:  state_d = B_LOOP;
      B_LOOP: begin
        case (tok_q.kind)
          TK_BINOP: begin
            if (!err_set && ocnt_q != '0 && pop_cond) state_d = B_POP;
            else state_d = B_IDLE;
          end
          TK_CLOSE: begin
            if (!err_set && ocnt_q != '0) state_d = B_POP;
            else state_d = B_IDLE;
          end
          TK_END: begin
            if (!err_set && ocnt_q != '0) state_d = B_POP;
            else state_d = B_OUT;
          end
          default: state_d = B_IDLE;
        endcase
      end
      B_POP: state_d = B_APPLY;
      B_APPLY: begin
        if (skip_q) begin
          state_d = (tok_q.kind == TK_CLOSE) ? B_IDLE : B_LOOP;
        end else if (cur_op == OP_MUL || cur_op == OP_POW ||
                     cur_op == OP_DIV || cur_op == OP_MOD) begin
          state_d = areq.start ? B_WAIT : B_LOOP;
        end else begin
          state_d = B_LOOP;
        end
      end
      B_WAIT: if (a_done) state_d = B_LOOP;
      B_OUT:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    op_we      = 1'b0;
    val_we     = 1'b0;
    areq.start = 1'b0;
    areq.op    = cur_op;
    areq.a     = val_rd_q;
    areq.b     = tv_q;
    case (state_q)
      B_NUM: begin
        val_we = tok_q.has_num && !err_set && vcnt_q < CW'(STACK_DEPTH) && vcnt_q != '0;
      end
      B_LOOP: begin
        if ((tok_q.kind == TK_OPEN || tok_q.kind == TK_NEG ||
             (tok_q.kind == TK_BINOP && !(ocnt_q != '0 && pop_cond))) &&
            !err_set && ocnt_q < CW'(STACK_DEPTH) && ocnt_q != '0) begin
          op_we = 1'b1;
        end
      end
      B_APPLY: begin
        if (!skip_q && !err_set && vcnt_q >= CW'(2)) begin
          case (cur_op)
            OP_MUL:         areq.start = 1'b1;
            OP_DIV, OP_MOD: areq.start = (tv_q != 64'd0);
            OP_POW:         areq.start = !tv_q[63];
            default:        areq.start = 1'b0;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_we) op_mem[ocnt_m1[AW-1:0]] <= ot_q;
    op_rd_q <= op_mem[ocnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[vcnt_m1[AW-1:0]] <= tv_q;
    val_rd_q <= val_mem[vcnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ocnt_q      <= '0;
      vcnt_q      <= '0;
      err_q       <= ST_OK;
      unbal_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && state_q != B_OUT) out_valid_q <= 1'b0;
      case (state_q)
        B_NUM: begin
          if (tok_q.has_num && !err_set) begin
            if (vcnt_q >= CW'(STACK_DEPTH)) err_q <= ST_OVER;
            else vcnt_q <= vcnt_q + CW'(1);
          end
        end
        B_LOOP: begin
          if ((tok_q.kind == TK_OPEN || tok_q.kind == TK_NEG ||
               (tok_q.kind == TK_BINOP && !(ocnt_q != '0 && pop_cond))) && !err_set) begin
            if (ocnt_q >= CW'(STACK_DEPTH)) err_q <= ST_OVER;
            else ocnt_q <= ocnt_q + CW'(1);
          end
          if (tok_q.kind == TK_END && !err_set && ocnt_q != '0 && top_op == OP_OPEN)
            unbal_q <= 1'b1;
        end
        B_POP: ocnt_q <= ocnt_m1;
        B_APPLY: begin
          if (!skip_q && !err_set) begin
            if (cur_op == OP_NEG) begin
              if (vcnt_q == '0) err_q <= ST_OPERAND;
            end else if (vcnt_q < CW'(2)) begin
              err_q <= ST_OPERAND;
            end else begin
              case (cur_op)
                OP_ADD, OP_SUB: vcnt_q <= vcnt_m1;
                OP_DIV, OP_MOD: if (tv_q == 64'd0) err_q <= ST_ZERO;
                OP_POW:         if (tv_q[63]) err_q <= ST_NEGEXP;
                OP_MUL:         err_q <= err_q;
                default:        err_q <= ST_OPERAND;
              endcase
            end
          end
        end
        B_WAIT: if (a_done) vcnt_q <= vcnt_m1;
        B_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ocnt_q      <= '0;
            vcnt_q      <= '0;
            err_q       <= ST_OK;
            unbal_q     <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: tok_q <= tok_i;
      B_NUM: begin
        if (tok_q.has_num && !err_set && vcnt_q < CW'(STACK_DEPTH)) tv_q <= tok_q.num;
      end
      B_LOOP: begin
        if ((tok_q.kind == TK_OPEN || tok_q.kind == TK_NEG ||
             (tok_q.kind == TK_BINOP && !(ocnt_q != '0 && pop_cond))) &&
            !err_set && ocnt_q < CW'(STACK_DEPTH)) begin
          ot_q <= tok_q.op;
        end
        // an open paren on top is dropped, not applied
        skip_q <= (top_op == OP_OPEN);
      end
      B_POP: cur_q <= ot_q;
      B_APPLY: begin
        if (ocnt_q != '0) ot_q <= op_rd_q;
        if (!skip_q && !err_set) begin
          if (cur_op == OP_NEG) begin
            tv_q <= 64'd0 - tv_q;
          end else if (vcnt_q >= CW'(2)) begin
            if (cur_op == OP_ADD) tv_q <= val_rd_q + tv_q;
            else if (cur_op == OP_SUB) tv_q <= val_rd_q - tv_q;
          end
        end
      end
      B_WAIT: if (a_done) tv_q <= a_res;
      B_OUT: begin
        if (out_free) begin
          out_q.status <= fin_st;
          out_q.value  <= (fin_st == ST_OK) ? tv_q : 64'd0;
        end
      end
      default: begin
      end
    endcase
  end

  `IEE_ASSERT_NOW(a_ocnt_bound, clk_i, rst_ni, 1'b1, ocnt_q <= CW'(STACK_DEPTH))
  `IEE_ASSERT_NOW(a_vcnt_bound, clk_i, rst_ni, 1'b1, vcnt_q <= CW'(STACK_DEPTH))
  `IEE_ASSERT_NOW(a_done_in_wait, clk_i, rst_ni, a_done, state_q == B_WAIT)
  `IEE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
                   state_q == B_OUT && out_valid_q && out_stall_i, state_q == B_OUT)

endmodule

/* dv/testbench.sv */
module testbench;
  import iee_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  item_t   in_data_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;

  infix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  item_t   char_queue[$];
  result_t expected_results[$];
  int      failures = 0;
  int      sender_idle_pct = 0;
  int      receiver_idle_pct = 0;
  bit      hold_receiver = 1'b0;
  int      chars_queued = 0;
  int      quiet_cycles = 0;

  // ---------------- evaluator model ----------------
  op_e         op_stack[DEPTH];
  int unsigned op_count;
  logic [63:0] num_stack[DEPTH];
  int unsigned num_count;
  logic [63:0] number_acc;
  bit          in_digits;
  logic [7:0]  last_char;
  bit          expr_start;
  int unsigned depth_count;
  bit          unbalanced;
  status_e     first_status;

  function automatic void clear_model();
    op_count = 0;
    num_count = 0;
    number_acc = '0;
    in_digits = 1'b0;
    last_char = '0;
    expr_start = 1'b1;
    depth_count = 0;
    unbalanced = 1'b0;
    first_status = ST_OK;
  endfunction

  function automatic void raise(status_e s);
    if (first_status == ST_OK) first_status = s;
  endfunction

  function automatic bit char_op(logic [7:0] c, output op_e op);
    op = OP_OPEN;
    case (c)
      CH_PLUS:  op = OP_ADD;
      CH_MINUS: op = OP_SUB;
      CH_STAR:  op = OP_MUL;
      CH_SLASH: op = OP_DIV;
      CH_PCT:   op = OP_MOD;
      CH_CARET: op = OP_POW;
      default:  return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic int rank(op_e op);
    case (op)
      OP_ADD, OP_SUB:         return 1;
      OP_MUL, OP_DIV, OP_MOD: return 2;
      OP_POW:                 return 3;
      OP_NEG:                 return 4;
      default:                return 0;
    endcase
  endfunction

  function automatic void push_num(logic [63:0] v);
    if (first_status != ST_OK) return;
    if (num_count >= DEPTH) begin
      raise(ST_OVER);
      return;
    end
    num_stack[num_count] = v;
    num_count++;
  endfunction

  function automatic void push_op(op_e op);
    if (first_status != ST_OK) return;
    if (op_count >= DEPTH) begin
      raise(ST_OVER);
      return;
    end
    op_stack[op_count] = op;
    op_count++;
  endfunction

  function automatic void reduce(op_e op);
    logic [63:0] a, b, r;
    if (first_status != ST_OK) return;
    if (op == OP_NEG) begin
      if (num_count < 1) begin
        raise(ST_OPERAND);
        return;
      end
      num_stack[num_count-1] = -num_stack[num_count-1];
      return;
    end
    if (num_count < 2) begin
      raise(ST_OPERAND);
      return;
    end
    b = num_stack[num_count-1];
    a = num_stack[num_count-2];
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          raise(ST_ZERO);
          return;
        end
        if (b == '1) r = (op == OP_DIV) ? -a : 64'd0;
        else if (op == OP_DIV) r = $signed(a) / $signed(b);
        else r = $signed(a) % $signed(b);
      end
      OP_POW: begin
        if (b[63]) begin
          raise(ST_NEGEXP);
          return;
        end
        r = 64'd1;
        while (b != 0) begin
          if (b[0]) r = r * a;
          a = a * a;
          b = b >> 1;
        end
      end
      default: begin
        raise(ST_OPERAND);
        return;
      end
    endcase
    num_count--;
    num_stack[num_count-1] = r;
  endfunction

  function automatic void close_number();
    if (in_digits) push_num(number_acc);
    in_digits = 1'b0;
    number_acc = '0;
  endfunction

  function automatic void take_char(logic [7:0] c);
    op_e cur, top, dummy;
    bit  is_op, prev_op;
    is_op = char_op(c, cur);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      number_acc = number_acc * 10 + 64'(c - CH_ZERO);
      in_digits = 1'b1;
      last_char = c;
      expr_start = 1'b0;
      return;
    end
    close_number();
    if (c == CH_LPAR) begin
      if (depth_count >= BAL_MAX) unbalanced = 1'b1;
      else depth_count++;
      push_op(OP_OPEN);
    end else if (c == CH_RPAR) begin
      if (depth_count == 0) begin
        unbalanced = 1'b1;
      end else begin
        depth_count--;
        while (first_status == ST_OK && op_count > 0 && op_stack[op_count-1] != OP_OPEN) begin
          op_count--;
          reduce(op_stack[op_count]);
        end
        if (first_status == ST_OK && op_count > 0) op_count--;
      end
    end else if (is_op) begin
      prev_op = char_op(last_char, dummy);
      if (cur == OP_SUB && (expr_start || last_char == CH_LPAR || prev_op)) begin
        push_op(OP_NEG);
      end else begin
        while (first_status == ST_OK && op_count > 0) begin
          top = op_stack[op_count-1];
          if (cur == OP_POW ? rank(top) <= rank(cur) : rank(top) < rank(cur)) break;
          op_count--;
          reduce(top);
        end
        push_op(cur);
      end
    end else begin
      return;
    end
    last_char = c;
    expr_start = 1'b0;
  endfunction

  function automatic result_t finish_expr();
    result_t res;
    op_e     top;
    close_number();
    while (first_status == ST_OK && op_count > 0) begin
      op_count--;
      top = op_stack[op_count];
      if (top == OP_OPEN) unbalanced = 1'b1;
      else reduce(top);
    end
    if (first_status == ST_OK && num_count != 1) raise(ST_OPERAND);
    res.status = (unbalanced || depth_count != 0) ? ST_UNBAL : first_status;
    res.value = (res.status == ST_OK) ? num_stack[0] : 64'sd0;
    clear_model();
    return res;
  endfunction

  // ---------------- stimulus ----------------
  function automatic void queue_char(logic op_bit, logic [7:0] c);
    item_t it;
    it.operation = op_bit;
    it.character = c;
    char_queue.push_back(it);
    chars_queued++;
  endfunction

  // noisy adds stray bytes between characters now and then
  function automatic void queue_expr(string s, bit noisy);
    for (int i = 0; i < s.len(); i++) begin
      if (noisy && $urandom_range(0, 29) == 0) queue_char(1'b0, 8'($urandom_range(0, 255)));
      queue_char(1'b0, s[i]);
    end
    // end item with random don't-care character
    queue_char(1'b1, 8'($urandom_range(0, 255)));
  endfunction

  function automatic string gen_number();
    string s;
    s = "";
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < $urandom_range(15, 20); i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end else begin
      s = $sformatf("%0d", $urandom_range(0, 40));
    end
    return s;
  endfunction

  function automatic string gen_term(int lvl);
    int r;
    r = $urandom_range(0, 9);
    if (lvl > 0 && r < 2) return {"(", gen_expr(lvl - 1), ")"};
    if (r == 2) return {"-", gen_term(lvl)};
    if (r == 3) return {" ", gen_number()};
    return gen_number();
  endfunction

  function automatic string gen_expr(int lvl);
    string s, ops;
    ops = "+-*/%^";
    s = gen_term(lvl);
    for (int i = 0; i < $urandom_range(0, 3); i++)
      s = {s, $sformatf("%c", ops[$urandom_range(0, 5)]), gen_term(lvl)};
    return s;
  endfunction

  function automatic string broken(string s);
    int p;
    if (s.len() < 2) return s;
    p = $urandom_range(0, s.len() - 1);
    case ($urandom_range(0, 2))
      0: return {s.substr(0, p - 1), s.substr(p + 1, s.len() - 1)};
      1: return {s.substr(0, p - 1), "(", s.substr(p, s.len() - 1)};
      default: return {s.substr(0, p - 1), ")", s.substr(p, s.len() - 1)};
    endcase
  endfunction

  function automatic void queue_random(int count);
    int target;
    string s;
    target = chars_queued + count;
    while (chars_queued < target) begin
      s = gen_expr($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) s = broken(s);
      queue_expr(s, $urandom_range(0, 4) == 0);
    end
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.operation) expected_results.push_back(finish_expr());
        else take_char(in_data_i.character);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (char_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_data_i <= char_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_stall_i <= hold_receiver || ($urandom_range(0, 99) < receiver_idle_pct);
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %0d status %0d",
               $signed(out_data_o.value), out_data_o.status);
        failures++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data_o.value !== exp_res.value) begin
          $error("value: expected %0d actual %0d", $signed(exp_res.value),
                 $signed(out_data_o.value));
          failures++;
        end
        if (out_data_o.status !== exp_res.status) begin
          $error("status: expected %0d actual %0d", exp_res.status, out_data_o.status);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (char_queue.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  initial begin
    string deep;
    clear_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed expressions
    queue_expr("1+2*3", 0);
    queue_expr("2^3^2", 0);
    queue_expr("-5--3*-(2)", 0);
    queue_expr("7/-2+(-7%3)", 0);
    queue_expr("5/0", 0);
    queue_expr("5%0", 0);
    queue_expr("2^-1", 0);
    queue_expr("3^0", 0);
    queue_expr("(-9223372036854775807-1)/-1", 0);
    queue_expr("(-9223372036854775807-1)%-1", 0);
    queue_expr("99999999999999999999999", 0);
    queue_expr("", 0);
    queue_expr("()", 0);
    queue_expr("(1+2", 0);
    queue_expr("1+2)", 0);
    queue_expr(")(", 0);
    queue_expr("1 +", 0);
    queue_expr("1 2", 0);
    queue_expr("3*(4+5)-6 a", 0);
    queue_expr("1/0+(", 0);
    deep = "";
    for (int i = 0; i < 70; i++) deep = {deep, "("};
    deep = {deep, "1"};
    for (int i = 0; i < 70; i++) deep = {deep, ")"};
    queue_expr(deep, 0);
    deep = "";
    for (int i = 0; i < 70; i++) deep = {deep, "1^"};
    queue_expr({deep, "1"}, 0);
    deep = "";
    for (int i = 0; i < 513; i++) deep = {deep, "("};
    queue_expr(deep, 0);

    sender_idle_pct = 23;
    receiver_idle_pct = 61;
    wait_drained();
    queue_random(15);
    wait_drained();

    sender_idle_pct = 61;
    receiver_idle_pct = 23;
    queue_random(15);
    wait_drained();

    // long receiver hold-off while the sender keeps offering items
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    queue_random(50);
    hold_receiver = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_receiver = 1'b0;
    wait_drained();

    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
